// ===== sv/msp_pkg.sv =====
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types and constants of the matrix saddle point finder: register
// indexes, controller states, and the command and status bundles.
// ----------------------------------------------------------------------------
package msp_pkg;

  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 5;
  localparam int ELEM_W       = 32;
  localparam int IDX_OUT_W    = 4;
  localparam int RESULT_LIMIT = 16;
  localparam int HIT_CNT_W    = $clog2(RESULT_LIMIT + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd1;

  typedef enum logic [2:0] {
    S_LOAD,
    S_ROW,
    S_ROW_WAIT,
    S_COL,
    S_COL_WAIT,
    S_DECIDE,
    S_END
  } msp_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load_we;       // store the accepted element
    logic search_start;  // clear row counter, hit count and pending hit
    logic row_rd;        // read element of current row, advance column
    logic col_rd;        // read element of candidate column, advance row
    logic decide;        // close current row, log hit if any
    logic finish;        // emit the final result
  } msp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic load_last;     // next element completes the matrix
    logic row_scan_last; // column counter at last column
    logic col_scan_last; // scan counter at last row
    logic row_last;      // current row is the last one
    logic hit_ok;        // current row maximum is a saddle point
    logic limit_next;    // a hit now reaches the result limit
  } msp_status_t;

endpackage

// ===== sv/matrix_saddle_point_finder.sv =====
// ----------------------------------------------------------------------------
// matrix_saddle_point_finder
// Loads a matrix in row-major order, then reports each row's first maximum that
// is also the minimum of its column, in row order, up to RESULT_LIMIT hits.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+---------------------------------
//  element   | start_i, busy_o           | element_value_i
//  config    | cfg_we_i                  | cfg_index_i, cfg_data_i
//  result    | result_valid_o (strobe)   | row_index_o, column_index_o,
//            |                           | found_o, last_result_o
//
//  An element item is taken on every edge with start_i high and busy_o low,
//  one per cycle while loading. The last element starts the search, during
//  which busy_o stays high: each row takes one memory read per cycle on the
//  single element memory port for the row and then its candidate column,
//  plus read latency and the decision, and a final state emits the final
//  result. Results are one-cycle strobes that the receiver cannot stall.
//  Reset clears the controller, counters and load position; the element
//  memory is not cleared, and only positions of a fully loaded matrix are read.
//
module matrix_saddle_point_finder #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [msp_pkg::ELEM_W-1:0]    element_value_i,
  input  logic                                 cfg_we_i,
  input  logic [msp_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [msp_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  output logic                                 result_valid_o,
  output logic [msp_pkg::IDX_OUT_W-1:0]        row_index_o,
  output logic [msp_pkg::IDX_OUT_W-1:0]        column_index_o,
  output logic                                 found_o,
  output logic                                 last_result_o
);
  import msp_pkg::*;

  msp_cmd_t    cmd;
  msp_status_t status;

  // Sequence load, row scan, column scan and reporting.
  msp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // Hold the matrix, track row maxima and column checks, drive results.
  msp_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .element_value_i (element_value_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .result_valid_o  (result_valid_o),
    .row_index_o     (row_index_o),
    .column_index_o  (column_index_o),
    .found_o         (found_o),
    .last_result_o   (last_result_o)
  );

endmodule

// ===== sv/msp_ctrl.sv =====
// ----------------------------------------------------------------------------
// msp_ctrl
// Sequencer of the saddle point finder: loading, row scan, column scan,
// per-row decision and final result.
// ----------------------------------------------------------------------------
module msp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  msp_pkg::msp_status_t status_i,
  output msp_pkg::msp_cmd_t    cmd_o,
  output logic                busy_o
);
  import msp_pkg::*;

  msp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      S_LOAD: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load_we = 1'b1;
          if (status_i.load_last) begin
            cmd_o.search_start = 1'b1;
            state_d = S_ROW;
          end
        end
      end
      S_ROW: begin
        cmd_o.row_rd = 1'b1;
        if (status_i.row_scan_last) begin
          state_d = S_ROW_WAIT;
        end
      end
      S_ROW_WAIT: begin
        state_d = S_COL;
      end
      S_COL: begin
        cmd_o.col_rd = 1'b1;
        if (status_i.col_scan_last) begin
          state_d = S_COL_WAIT;
        end
      end
      S_COL_WAIT: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        if ((status_i.hit_ok && status_i.limit_next) || status_i.row_last) begin
          state_d = S_END;
        end else begin
          state_d = S_ROW;
        end
      end
      S_END: begin
        cmd_o.finish = 1'b1;
        state_d = S_LOAD;
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

endmodule

// ===== sv/msp_dp.sv =====
// ----------------------------------------------------------------------------
// msp_dp
// Datapath of the saddle point finder: configuration registers, element
// memory, scan counters, row maximum and column minimum checks, result
// registers.
// ----------------------------------------------------------------------------
module msp_dp #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [msp_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [msp_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic signed [msp_pkg::ELEM_W-1:0]    element_value_i,
  input  msp_pkg::msp_cmd_t                    cmd_i,
  output msp_pkg::msp_status_t                 status_o,
  output logic                                 result_valid_o,
  output logic [msp_pkg::IDX_OUT_W-1:0]        row_index_o,
  output logic [msp_pkg::IDX_OUT_W-1:0]        column_index_o,
  output logic                                 found_o,
  output logic                                 last_result_o
);
  import msp_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW    = $clog2(DEPTH + 1);
  localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int NRW   = $clog2(MAX_ROWS + 1);
  localparam int NCW   = $clog2(MAX_COLS + 1);
  localparam int MAXRC = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int SW    = (MAXRC > 1) ? $clog2(MAXRC) : 1;

  function automatic logic [NRW-1:0] clamp_rows(logic [CFG_DATA_W-1:0] v);
    if (v == '0) return NRW'(1);
    if (32'(v) > MAX_ROWS) return NRW'(MAX_ROWS);
    return NRW'(v);
  endfunction

  function automatic logic [NCW-1:0] clamp_cols(logic [CFG_DATA_W-1:0] v);
    if (v == '0) return NCW'(1);
    if (32'(v) > MAX_COLS) return NCW'(MAX_COLS);
    return NCW'(v);
  endfunction

  logic [CFG_DATA_W-1:0] row_count_q, column_count_q;
  logic [NRW-1:0]        rows_eff;
  logic [NCW-1:0]        cols_eff;
  logic [TW-1:0]         total;
  logic [AW-1:0]         load_pos_q;
  logic [RIW-1:0]        row_q;
  logic [SW-1:0]         scan_q;
  logic [AW-1:0]         mem_addr;

  logic signed [ELEM_W-1:0] mem_q [DEPTH];
  logic signed [ELEM_W-1:0] rdata_q;
  logic                     rd_row_q, rd_first_q, rd_col_q;
  logic [CIW-1:0]           rd_idx_q;

  logic signed [ELEM_W-1:0] best_q;
  logic [CIW-1:0]           best_col_q;
  logic                     ok_q;

  logic [HIT_CNT_W-1:0]     hit_cnt_q;
  logic                     pend_v_q;
  logic [RIW-1:0]           pend_row_q;
  logic [CIW-1:0]           pend_col_q;

  logic                     out_v_q, out_found_q, out_last_q;
  logic [IDX_OUT_W-1:0]     out_row_q, out_col_q;

  assign rows_eff = clamp_rows(row_count_q);
  assign cols_eff = clamp_cols(column_count_q);
  assign total    = TW'(rows_eff) * TW'(cols_eff);

  assign status_o.load_last     = (32'(load_pos_q) + 1) == 32'(total);
  assign status_o.row_scan_last = (32'(scan_q) + 1) == 32'(cols_eff);
  assign status_o.col_scan_last = (32'(scan_q) + 1) == 32'(rows_eff);
  assign status_o.row_last      = (32'(row_q) + 1) == 32'(rows_eff);
  assign status_o.hit_ok        = ok_q;
  assign status_o.limit_next    = hit_cnt_q == HIT_CNT_W'(RESULT_LIMIT - 1);

  always_comb begin
    if (cmd_i.row_rd) begin
      mem_addr = AW'(AW'(row_q) * AW'(cols_eff) + AW'(scan_q));
    end else if (cmd_i.col_rd) begin
      mem_addr = AW'(AW'(scan_q) * AW'(cols_eff) + AW'(best_col_q));
    end else begin
      mem_addr = load_pos_q;
    end
  end

  // Element memory: one port, write during load, registered read in search.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we) begin
      mem_q[mem_addr] <= element_value_i;
    end
    rdata_q <= mem_q[mem_addr];
  end

  // Configuration and load position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= CFG_DATA_W'(1);
      column_count_q <= CFG_DATA_W'(1);
      load_pos_q     <= '0;
    end else begin
      if (cfg_we_i && cfg_index_i == CFG_ROW_COUNT) begin
        row_count_q <= cfg_data_i;
        load_pos_q  <= '0;
      end else if (cfg_we_i && cfg_index_i == CFG_COLUMN_COUNT) begin
        column_count_q <= cfg_data_i;
        load_pos_q     <= '0;
      end else if (cmd_i.search_start) begin
        load_pos_q <= '0;
      end else if (cmd_i.load_we) begin
        load_pos_q <= load_pos_q + AW'(1);
      end
    end
  end

  // Scan control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      scan_q     <= '0;
      rd_row_q   <= 1'b0;
      rd_col_q   <= 1'b0;
      rd_first_q <= 1'b0;
      hit_cnt_q  <= '0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      rd_row_q   <= cmd_i.row_rd;
      rd_col_q   <= cmd_i.col_rd;
      rd_first_q <= cmd_i.row_rd && scan_q == '0;
      out_v_q    <= cmd_i.finish || (cmd_i.decide && ok_q && pend_v_q);
      if (cmd_i.search_start) begin
        row_q     <= '0;
        scan_q    <= '0;
        hit_cnt_q <= '0;
        pend_v_q  <= 1'b0;
      end
      if (cmd_i.row_rd) begin
        scan_q <= status_o.row_scan_last ? '0 : scan_q + SW'(1);
      end
      if (cmd_i.col_rd) begin
        scan_q <= status_o.col_scan_last ? '0 : scan_q + SW'(1);
      end
      if (cmd_i.decide) begin
        row_q <= row_q + RIW'(1);
        if (ok_q) begin
          hit_cnt_q <= hit_cnt_q + HIT_CNT_W'(1);
          pend_v_q  <= 1'b1;
        end
      end
    end
  end

  // Row maximum, column check, pending hit and result payload.
  always_ff @(posedge clk_i) begin
    rd_idx_q <= CIW'(scan_q);
    if (cmd_i.row_rd && scan_q == '0) begin
      ok_q <= 1'b1;
    end
    if (rd_row_q && (rd_first_q || rdata_q > best_q)) begin
      best_q     <= rdata_q;
      best_col_q <= rd_idx_q;
    end
    if (rd_col_q && rdata_q < best_q) begin
      ok_q <= 1'b0;
    end
    if (cmd_i.decide && ok_q) begin
      // Hand the previous hit out, hold the new one until more is known.
      pend_row_q  <= row_q;
      pend_col_q  <= best_col_q;
      out_row_q   <= IDX_OUT_W'(pend_row_q);
      out_col_q   <= IDX_OUT_W'(pend_col_q);
      out_found_q <= 1'b1;
      out_last_q  <= 1'b0;
    end
    if (cmd_i.finish) begin
      out_row_q   <= pend_v_q ? IDX_OUT_W'(pend_row_q) : '0;
      out_col_q   <= pend_v_q ? IDX_OUT_W'(pend_col_q) : '0;
      out_found_q <= pend_v_q;
      out_last_q  <= 1'b1;
    end
  end

  assign result_valid_o = out_v_q;
  assign row_index_o    = out_row_q;
  assign column_index_o = out_col_q;
  assign found_o        = out_found_q;
  assign last_result_o  = out_last_q;

endmodule
